>>> rtl/sshr_pkg.sv
package sshr_pkg;

  // Ring geometry
  localparam int HISTORY_DEPTH = 16;
  localparam int IDX_W         = $clog2(HISTORY_DEPTH);
  localparam int CNT_W         = $clog2(HISTORY_DEPTH + 1);
  localparam int MAX_RESULTS   = 16;

  // Field widths
  localparam int FUNC_W  = 2;
  localparam int N_W     = 5;
  localparam int RAWP_W  = 24;
  localparam int VAL_W   = 16;
  localparam int STAMP_W = 32;
  localparam int WORD_W  = 64;

  // Queue depths
  localparam int CMD_DEPTH = 2;
  localparam int OUT_DEPTH = 4;

  // Function selector codes
  localparam logic [FUNC_W-1:0] FUNC_STORE  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_READ_P = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ_T = 2'd2;

  typedef enum logic [1:0] {
    OP_STORE,
    OP_READ_P,
    OP_READ_T,
    OP_REJECT
  } op_e;

  // Classified command from front to back
  typedef struct packed {
    op_e                op;
    logic [IDX_W-1:0]   addr;
    logic [N_W-1:0]     len;
    logic [VAL_W-1:0]   pressure;
    logic [VAL_W-1:0]   temperature;
    logic [STAMP_W-1:0] stamp;
  } cmd_t;

  // One ring entry
  typedef struct packed {
    logic [VAL_W-1:0]   pressure;
    logic [VAL_W-1:0]   temperature;
    logic [STAMP_W-1:0] stamp;
  } ent_t;

  // One result word
  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              last;
    logic              rej;
  } res_t;

endpackage

>>> rtl/sshr_front.sv
module sshr_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        acc_i,
  input  logic [sshr_pkg::FUNC_W-1:0] func_i,
  input  logic [sshr_pkg::RAWP_W-1:0] raw_pressure_i,
  input  logic [sshr_pkg::VAL_W-1:0]  raw_temperature_i,
  input  logic [sshr_pkg::STAMP_W-1:0] sample_time_i,
  input  logic [sshr_pkg::N_W-1:0]    records_wanted_i,
  output logic                        cmd_push_o,
  output sshr_pkg::cmd_t              cmd_o
);
  import sshr_pkg::*;

  logic [IDX_W-1:0]    wpos_q, wpos_d;
  logic [CNT_W-1:0]    fill_q, fill_d;
  logic [RAWP_W+3:0]   prod;
  logic [IDX_W-1:0]    newest;
  logic                refuse;
  logic [N_W-1:0]      len;

  // Scale pressure: floor(raw * 10 / 4096)
  assign prod = {3'b000, raw_pressure_i, 1'b0} + {1'b0, raw_pressure_i, 3'b000};

  // Newest entry sits one behind the write position
  assign newest = (wpos_q == '0) ? IDX_W'(HISTORY_DEPTH - 1) : wpos_q - 1'b1;

  assign refuse = (records_wanted_i == '0) ||
                  (32'(records_wanted_i) > 32'(fill_q));
  assign len    = (32'(records_wanted_i) > 32'(MAX_RESULTS)) ?
                  N_W'(MAX_RESULTS) : records_wanted_i;

  // Classify the incoming word
  always_comb begin
    cmd_o.addr        = newest;
    cmd_o.len         = len;
    cmd_o.pressure    = prod[RAWP_W+3:12];
    cmd_o.temperature = raw_temperature_i;
    cmd_o.stamp       = sample_time_i;
    cmd_o.op          = OP_REJECT;
    cmd_push_o        = acc_i;
    wpos_d            = wpos_q;
    fill_d            = fill_q;
    case (func_i)
      FUNC_STORE: begin
        cmd_o.op   = OP_STORE;
        cmd_o.addr = wpos_q;
        if (acc_i) begin
          wpos_d = (wpos_q == IDX_W'(HISTORY_DEPTH - 1)) ? '0 : wpos_q + 1'b1;
          if (fill_q != CNT_W'(HISTORY_DEPTH)) begin
            fill_d = fill_q + 1'b1;
          end
        end
      end
      FUNC_READ_P: begin
        cmd_o.op = refuse ? OP_REJECT : OP_READ_P;
      end
      FUNC_READ_T: begin
        cmd_o.op = refuse ? OP_REJECT : OP_READ_T;
      end
      default: begin
        cmd_push_o = 1'b0;
      end
    endcase
  end

  // Track ring position and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wpos_q <= '0;
      fill_q <= '0;
    end else begin
      wpos_q <= wpos_d;
      fill_q <= fill_d;
    end
  end

endmodule

>>> rtl/sshr_cmd_queue.sv
module sshr_cmd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  sshr_pkg::cmd_t data_i,
  input  logic           pop_i,
  output sshr_pkg::cmd_t data_o,
  output logic           empty_o,
  output logic           full_o
);
  import sshr_pkg::*;

  localparam int PTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
  localparam int QC_W  = $clog2(CMD_DEPTH + 1);

  cmd_t              slot_q [CMD_DEPTH];
  logic [PTR_W-1:0]  wptr_q, rptr_q;
  logic [QC_W-1:0]   cnt_q;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == QC_W'(CMD_DEPTH));
  assign data_o  = slot_q[rptr_q];

  // Store incoming word
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= data_i;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == PTR_W'(CMD_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == PTR_W'(CMD_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      cnt_q <= cnt_q + QC_W'(push_i) - QC_W'(pop_i);
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QC_W'(CMD_DEPTH)) else $error("command queue count overflow");
  a_no_over: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o || pop_i) else $error("command queue written while full");
  a_no_under: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("command queue read while empty");

endmodule

>>> rtl/sshr_back.sv
module sshr_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  sshr_pkg::cmd_t               cmd_i,
  input  logic                         cmd_empty_i,
  output logic                         cmd_pop_o,
  input  logic                         pop_i,
  output logic                         empty_o,
  output logic [sshr_pkg::WORD_W-1:0]  record_word_o,
  output logic                         last_record_o,
  output logic                         rejected_o
);
  import sshr_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  localparam int OPTR_W = $clog2(OUT_DEPTH);
  localparam int OCNT_W = $clog2(OUT_DEPTH + 1);

  // Sequencer state
  logic              state_q, state_d;
  logic [IDX_W-1:0]  addr_q, addr_d;
  logic [N_W-1:0]    left_q, left_d;
  logic              temp_q, temp_d;

  // Issue controls
  logic              space;
  logic              iss_vld, iss_rej, iss_last, iss_temp;
  logic [IDX_W-1:0]  rd_addr;
  logic              wr_en;

  // Ring memory and read stage
  ent_t              mem [HISTORY_DEPTH];
  ent_t              rd_q;
  logic              stg_vld_q, stg_rej_q, stg_last_q, stg_temp_q;
  res_t              stg_res;

  // Result queue
  res_t              oq_q [OUT_DEPTH];
  logic [OPTR_W-1:0] owp_q, orp_q;
  logic [OCNT_W-1:0] ocnt_q;
  logic              opop;

  assign space = (ocnt_q + OCNT_W'(stg_vld_q)) < OCNT_W'(OUT_DEPTH);

  // Pick the next command or the next record of a read
  always_comb begin
    state_d   = state_q;
    addr_d    = addr_q;
    left_d    = left_q;
    temp_d    = temp_q;
    cmd_pop_o = 1'b0;
    wr_en     = 1'b0;
    iss_vld   = 1'b0;
    iss_rej   = 1'b0;
    iss_last  = 1'b0;
    iss_temp  = temp_q;
    rd_addr   = addr_q;
    case (state_q)
      S_IDLE: begin
        if (!cmd_empty_i) begin
          case (cmd_i.op)
            OP_STORE: begin
              cmd_pop_o = 1'b1;
              wr_en     = 1'b1;
            end
            OP_REJECT: begin
              if (space) begin
                cmd_pop_o = 1'b1;
                iss_vld   = 1'b1;
                iss_rej   = 1'b1;
                iss_last  = 1'b1;
              end
            end
            OP_READ_P, OP_READ_T: begin
              cmd_pop_o = 1'b1;
              addr_d    = cmd_i.addr;
              left_d    = cmd_i.len;
              temp_d    = (cmd_i.op == OP_READ_T);
              state_d   = S_READ;
            end
            default: begin
              cmd_pop_o = 1'b0;
            end
          endcase
        end
      end
      S_READ: begin
        if (space) begin
          iss_vld  = 1'b1;
          iss_last = (left_q == N_W'(1));
          left_d   = left_q - 1'b1;
          addr_d   = (addr_q == '0) ? IDX_W'(HISTORY_DEPTH - 1) : addr_q - 1'b1;
          if (iss_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      addr_q  <= '0;
      left_q  <= '0;
      temp_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      addr_q  <= addr_d;
      left_q  <= left_d;
      temp_q  <= temp_d;
    end
  end

  // Write and read the ring
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[cmd_i.addr] <= '{pressure: cmd_i.pressure, temperature: cmd_i.temperature,
                           stamp: cmd_i.stamp};
    end
    if (iss_vld && !iss_rej) begin
      rd_q <= mem[rd_addr];
    end
  end

  // Hold per-record flags alongside the read data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_vld_q  <= 1'b0;
      stg_rej_q  <= 1'b0;
      stg_last_q <= 1'b0;
      stg_temp_q <= 1'b0;
    end else begin
      stg_vld_q  <= iss_vld;
      stg_rej_q  <= iss_rej;
      stg_last_q <= iss_last;
      stg_temp_q <= iss_temp;
    end
  end

  // Format the big-endian record
  always_comb begin
    stg_res.last = stg_last_q;
    stg_res.rej  = stg_rej_q;
    if (stg_rej_q) begin
      stg_res.word = '0;
    end else if (stg_temp_q) begin
      stg_res.word = {rd_q.temperature, 16'h0000, rd_q.stamp};
    end else begin
      stg_res.word = {8'h00, rd_q.pressure, 8'h00, rd_q.stamp};
    end
  end

  // Result queue
  assign empty_o       = (ocnt_q == '0);
  assign opop          = pop_i && !empty_o;
  assign record_word_o = oq_q[orp_q].word;
  assign last_record_o = oq_q[orp_q].last;
  assign rejected_o    = oq_q[orp_q].rej;

  always_ff @(posedge clk_i) begin
    if (stg_vld_q) begin
      oq_q[owp_q] <= stg_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owp_q  <= '0;
      orp_q  <= '0;
      ocnt_q <= '0;
    end else begin
      if (stg_vld_q) begin
        owp_q <= (owp_q == OPTR_W'(OUT_DEPTH - 1)) ? '0 : owp_q + 1'b1;
      end
      if (opop) begin
        orp_q <= (orp_q == OPTR_W'(OUT_DEPTH - 1)) ? '0 : orp_q + 1'b1;
      end
      ocnt_q <= ocnt_q + OCNT_W'(stg_vld_q) - OCNT_W'(opop);
    end
  end

  a_oq_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stg_vld_q |-> ocnt_q < OCNT_W'(OUT_DEPTH)) else $error("result queue overrun");
  a_read_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_READ |-> left_q != '0) else $error("read active with nothing left");
  a_issue_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    iss_vld |-> space) else $error("record issued without result room");
  a_rej_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stg_vld_q && stg_rej_q |-> stg_last_q) else $error("rejected word not marked last");

endmodule

>>> rtl/sensor_sample_history_ring_core.sv
// A read's first record reaches the result ports via the command queue, the
// sequencer state, read stage and result queue; a refused read's single word
// skips the sequencer state; stores give no word. One item per cycle enters a
// 2-word command queue while it is not full; the back end reads records through
// the ring memory's single read port. Reset clears pointers, counts and state.
module sensor_sample_history_ring_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic [sshr_pkg::FUNC_W-1:0]   func_i,
  input  logic [sshr_pkg::RAWP_W-1:0]   raw_pressure_i,
  input  logic [sshr_pkg::VAL_W-1:0]    raw_temperature_i,
  input  logic [sshr_pkg::STAMP_W-1:0]  sample_time_i,
  input  logic [sshr_pkg::N_W-1:0]      records_wanted_i,
  output logic                          empty,
  input  logic                          pop,
  output logic [sshr_pkg::WORD_W-1:0]   record_word_o,
  output logic                          last_record_o,
  output logic                          rejected_o
);
  import sshr_pkg::*;

  logic acc;
  logic cmd_push, cmd_pop, cmd_empty, cmd_full;
  cmd_t cmd_in, cmd_out;

  assign full = cmd_full;
  assign acc  = push && !cmd_full;

  sshr_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .acc_i             (acc),
    .func_i            (func_i),
    .raw_pressure_i    (raw_pressure_i),
    .raw_temperature_i (raw_temperature_i),
    .sample_time_i     (sample_time_i),
    .records_wanted_i  (records_wanted_i),
    .cmd_push_o        (cmd_push),
    .cmd_o             (cmd_in)
  );

  sshr_cmd_queue u_cmd_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .pop_i   (cmd_pop),
    .data_o  (cmd_out),
    .empty_o (cmd_empty),
    .full_o  (cmd_full)
  );

  sshr_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd_out),
    .cmd_empty_i   (cmd_empty),
    .cmd_pop_o     (cmd_pop),
    .pop_i         (pop),
    .empty_o       (empty),
    .record_word_o (record_word_o),
    .last_record_o (last_record_o),
    .rejected_o    (rejected_o)
  );

endmodule
